@@ design/bkvt_pkg.sv @@
// bkvt_pkg: action codes, configuration constants and the per-slot control word
// for the bounded key/value table. No dependencies.
`timescale 1ns / 1ps

package bkvt_pkg;

    localparam int ACT_W = 3;
    localparam int CFG_W = 5;

    localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UPDATE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UPSERT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ERASE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_GET_KEY  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_GET_SLOT = 3'd5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic sel;
        logic wr_key;
        logic wr_val;
    } cell_ctl_t;

endpackage

@@ design/bkvt_cell.sv @@
// bkvt_cell: one slot of the table; holds a key and value, matches the search key
// and adds its word onto the read chain. Depends on bkvt_pkg.
`timescale 1ns / 1ps

module bkvt_cell
    import bkvt_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  cell_ctl_t              ctl,
    input  logic                   live,
    input  logic [KEY_WIDTH-1:0]   cmp_key,
    input  logic [KEY_WIDTH-1:0]   wr_key_data,
    input  logic [VALUE_WIDTH-1:0] wr_val_data,
    input  logic                   hit_in,
    input  logic [KEY_WIDTH-1:0]   rd_key_in,
    input  logic [VALUE_WIDTH-1:0] rd_val_in,
    output logic                   hit,
    output logic                   hit_out,
    output logic [KEY_WIDTH-1:0]   rd_key_out,
    output logic [VALUE_WIDTH-1:0] rd_val_out
);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_key)
        begin
            key_reg <= wr_key_data;
        end
        if (ctl.wr_val)
        begin
            val_reg <= wr_val_data;
        end
    end

    assign hit        = live && (key_reg == cmp_key);
    assign hit_out    = hit_in | hit;
    assign rd_key_out = rd_key_in | (ctl.sel ? key_reg : '0);
    assign rd_val_out = rd_val_in | (ctl.sel ? val_reg : '0);

endmodule

@@ design/bounded_key_value_table.sv @@
// bounded_key_value_table: top level; request sequencer, capacity register and the
// row of bkvt_cell slots. Depends on bkvt_pkg and bkvt_cell.
`timescale 1ns / 1ps
//
//  channel   | handshake                 | word
//  ----------+---------------------------+-------------------------------------------
//  request   | start, busy               | action, key, value, slot_index
//  result    | done (one-cycle strobe)   | ok, found_key, found_value, entry_count,
//            |                           | is_empty
//  config    | cfg_valid, cfg_ready      | cfg_data (capacity)
//
//  Per request, the accept edge runs the key match across all cells and captures the
//  read chain; the edge that ends EXEC writes back and registers the result.
//  done pulses in the cycle after that, when busy is already low again.
//  Reset clears the count and sets capacity to 16; slot contents are not cleared.
//  The receiver cannot stall; done pulses for one cycle, but the result outputs hold.

module bounded_key_value_table
    import bkvt_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ACT_W-1:0]       action,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [CNT_W-1:0]       slot_index,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic                   done,
    output logic                   ok,
    output logic [KEY_WIDTH-1:0]   found_key,
    output logic [VALUE_WIDTH-1:0] found_value,
    output logic [CNT_W-1:0]       entry_count,
    output logic                   is_empty
);

    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                   state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CFG_W-1:0]       capacity_reg;
    logic [ACT_W-1:0]       act_reg;
    logic [KEY_WIDTH-1:0]   req_key_reg;
    logic [VALUE_WIDTH-1:0] req_val_reg;
    logic [DEPTH-1:0]       hit_vec_reg;
    logic                   hit_any_reg;
    logic                   slot_ok_reg;
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic                   done_reg;
    logic                   ok_reg, ok_next;
    logic [KEY_WIDTH-1:0]   fk_reg, fk_next;
    logic [VALUE_WIDTH-1:0] fv_reg, fv_next;

    logic                   accept;
    logic                   exec;
    logic [CNT_W-1:0]       last_slot;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   room;
    logic                   do_ins, do_upd, do_erase;

    logic [DEPTH-1:0]       live;
    logic [DEPTH-1:0]       hit_vec;
    logic [DEPTH-1:0]       rd_sel;
    logic [DEPTH-1:0]       at_count;
    cell_ctl_t              ctl [DEPTH];
    logic [DEPTH:0]         hit_chain;
    logic [KEY_WIDTH-1:0]   rd_key_chain [DEPTH+1];
    logic [VALUE_WIDTH-1:0] rd_val_chain [DEPTH+1];
    logic [KEY_WIDTH-1:0]   wr_key_data;
    logic [VALUE_WIDTH-1:0] wr_val_data;

    assign accept    = start && !busy;
    assign exec      = (state_reg == ST_EXEC);
    assign busy      = exec;
    assign cfg_ready = 1'b1;
    assign last_slot = count_reg - CNT_W'(1);
    assign cap_ext   = CMP_W'(capacity_reg);
    assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign room      = CMP_W'(count_reg) < eff_cap;

    assign hit_chain[0]    = 1'b0;
    assign rd_key_chain[0] = '0;
    assign rd_val_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_slot
            assign live[gi]     = count_reg > CNT_W'(gi);
            assign at_count[gi] = count_reg == CNT_W'(gi);

            bkvt_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl[gi]),
                .live        (live[gi]),
                .cmp_key     (key),
                .wr_key_data (wr_key_data),
                .wr_val_data (wr_val_data),
                .hit_in      (hit_chain[gi]),
                .rd_key_in   (rd_key_chain[gi]),
                .rd_val_in   (rd_val_chain[gi]),
                .hit         (hit_vec[gi]),
                .hit_out     (hit_chain[gi+1]),
                .rd_key_out  (rd_key_chain[gi+1]),
                .rd_val_out  (rd_val_chain[gi+1])
            );
        end
    endgenerate

    // read select while idle: last entry for erase, hit slot or indexed slot for gets
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            case (action)
                ACT_ERASE:    rd_sel[i] = (last_slot == CNT_W'(i));
                ACT_GET_KEY:  rd_sel[i] = hit_vec[i];
                ACT_GET_SLOT: rd_sel[i] = (slot_index == CNT_W'(i));
                default:      rd_sel[i] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        do_ins   = 1'b0;
        do_upd   = 1'b0;
        do_erase = 1'b0;
        ok_next  = 1'b0;
        fk_next  = '0;
        fv_next  = '0;
        case (act_reg)
            ACT_INSERT:
            begin
                do_ins  = room && !hit_any_reg;
                ok_next = do_ins;
            end
            ACT_UPDATE:
            begin
                do_upd  = hit_any_reg;
                ok_next = hit_any_reg;
            end
            ACT_UPSERT:
            begin
                do_upd  = hit_any_reg;
                do_ins  = !hit_any_reg && room;
                ok_next = do_upd || do_ins;
            end
            ACT_ERASE:
            begin
                do_erase = hit_any_reg;
                ok_next  = hit_any_reg;
            end
            ACT_GET_KEY:
            begin
                ok_next = hit_any_reg;
                fv_next = hit_any_reg ? rd_val_reg : '0;
            end
            ACT_GET_SLOT:
            begin
                ok_next = slot_ok_reg;
                fk_next = slot_ok_reg ? rd_key_reg : '0;
                fv_next = slot_ok_reg ? rd_val_reg : '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign wr_key_data = do_erase ? rd_key_reg : req_key_reg;
    assign wr_val_data = do_erase ? rd_val_reg : req_val_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl[i].sel    = rd_sel[i];
            ctl[i].wr_key = exec && ((do_ins && at_count[i]) || (do_erase && hit_vec_reg[i]));
            ctl[i].wr_val = exec && ((do_ins && at_count[i])
                                     || ((do_upd || do_erase) && hit_vec_reg[i]));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        state_next = state_reg;
        if (exec)
        begin
            state_next = ST_IDLE;
            if (do_ins)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (do_erase)
            begin
                count_next = last_slot;
            end
        end
        else if (accept)
        begin
            state_next = ST_EXEC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= exec;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= action;
            req_key_reg <= key;
            req_val_reg <= value;
            hit_vec_reg <= hit_vec;
            hit_any_reg <= hit_chain[DEPTH];
            slot_ok_reg <= slot_index < count_reg;
            rd_key_reg  <= rd_key_chain[DEPTH];
            rd_val_reg  <= rd_val_chain[DEPTH];
        end
        if (exec)
        begin
            ok_reg <= ok_next;
            fk_reg <= fk_next;
            fv_reg <= fv_next;
        end
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign found_key   = fk_reg;
    assign found_value = fv_reg;
    assign entry_count = count_reg;
    assign is_empty    = (count_reg == '0);

endmodule
